// ----- hdl/ridb_pkg.sv -----
package ridb_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;

	localparam int CW       = (COORD_BITS < 29) ? COORD_BITS : 29;
	localparam int DW       = CW + 1;
	localparam int PW       = 2 * DW;
	localparam int XW       = PW + 1;
	localparam int MW       = XW + 1;
	localparam int HW       = (MW + 1) / 2;
	localparam int WW       = 4 * HW;
	localparam int SW       = WW + 16;
	localparam int QW       = 2 * CW + 3;
	localparam int RW       = WW - QW;
	localparam int SQW      = 2 * CW + 4;
	localparam int RTW      = SQW / 2;
	localparam int RESW     = RTW + 1;
	localparam int OUT_BITS = COORD_BITS + 3;

	localparam longint UNIT2   = longint'(1) << (2 * FRAC_BITS);
	localparam longint LEN_TOL = (UNIT2 + 9999) / 10000;
	localparam longint DEN_TOL = UNIT2 / 10000;

	typedef logic signed [CW-1:0]  coord_t;
	typedef logic signed [DW-1:0]  diff_t;
	typedef logic signed [PW-1:0]  prod_t;
	typedef logic        [PW-1:0]  sq_t;
	typedef logic signed [XW-1:0]  cross_t;
	typedef logic signed [MW-1:0]  sden_t;
	typedef logic        [MW-1:0]  mag_t;
	typedef logic        [2*HW-1:0] part_t;
	typedef logic        [WW-1:0]  wide_t;
	typedef logic signed [SW-1:0]  cmp_t;
	typedef logic        [QW-1:0]  quo_t;
	typedef logic        [RW-1:0]  rem_t;
	typedef logic        [SQW-1:0] rad_t;
	typedef logic        [RTW-1:0] root_t;
	typedef logic        [RESW-1:0] res_t;

	typedef struct packed {
		sq_t  len2;
		sq_t  sq_rg;
		sq_t  sqa_r;
		sq_t  sqa_g;
		sq_t  sqb_r;
		sq_t  sqb_g;
		logic len_small;
		logic refl;
		logic direct;
	} side_t;

	typedef struct packed {
		logic len_small;
		logic direct;
	} flg_t;

	function automatic mag_t mag_of(input sden_t v);
		mag_t m;
		m = (v < 0) ? mag_t'(-v) : mag_t'(v);
		return m;
	endfunction

endpackage

// ----- hdl/ridb_div.sv -----
module ridb_div (
	input  logic            clk,
	input  logic            ce,
	input  ridb_pkg::wide_t num,
	input  ridb_pkg::sq_t   den,
	output ridb_pkg::quo_t  quo
);
	import ridb_pkg::*;

	rem_t rem_q [QW];
	quo_t nlo_q [QW];
	quo_t q_q   [QW];
	sq_t  d_q   [QW];

	genvar k;
	for (k = 0; k < QW; k++) begin : g_st
		rem_t          rem_i;
		quo_t          nlo_i;
		quo_t          q_i;
		sq_t           d_i;
		logic [RW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i = num[WW-1:QW];
			assign nlo_i = num[QW-1:0];
			assign q_i   = '0;
			assign d_i   = den;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign nlo_i = nlo_q[k-1];
			assign q_i   = q_q[k-1];
			assign d_i   = d_q[k-1];
		end

		assign t  = {rem_i, nlo_i[QW-1]};
		assign ge = t >= (RW+1)'(d_i);

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_q[k] <= ge ? RW'(t - (RW+1)'(d_i)) : RW'(t);
				nlo_q[k] <= nlo_i << 1;
				q_q[k]   <= {q_i[QW-2:0], ge};
				d_q[k]   <= d_i;
			end
		end
	end

	assign quo = q_q[QW-1];

endmodule

// ----- hdl/ridb_isqrt.sv -----
module ridb_isqrt (
	input  logic            clk,
	input  logic            ce,
	input  ridb_pkg::rad_t  rad,
	output ridb_pkg::root_t root
);
	import ridb_pkg::*;

	rad_t n_q [RTW];
	rad_t r_q [RTW];

	genvar k;
	for (k = 0; k < RTW; k++) begin : g_st
		rad_t         n_i;
		rad_t         r_i;
		rad_t         bitv;
		logic [SQW:0] sub;
		logic         ge;

		if (k == 0) begin : g_first
			assign n_i = rad;
			assign r_i = '0;
		end else begin : g_next
			assign n_i = n_q[k-1];
			assign r_i = r_q[k-1];
		end

		assign bitv = rad_t'(1) << (SQW - 2 - 2 * k);
		assign sub  = {1'b0, r_i} + {1'b0, bitv};
		assign ge   = {1'b0, n_i} >= sub;

		always_ff @(posedge clk) begin
			if (ce) begin
				n_q[k] <= ge ? SQW'({1'b0, n_i} - sub) : n_i;
				r_q[k] <= ge ? (r_i >> 1) + bitv : (r_i >> 1);
			end
		end
	end

	assign root = r_q[RTW-1][RTW-1:0];

endmodule

// ----- hdl/ridb_front.sv -----
module ridb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_vld,
	input  ridb_pkg::coord_t rx,
	input  ridb_pkg::coord_t ry,
	input  ridb_pkg::coord_t ax,
	input  ridb_pkg::coord_t ay,
	input  ridb_pkg::coord_t bx,
	input  ridb_pkg::coord_t by,
	input  ridb_pkg::coord_t gx,
	input  ridb_pkg::coord_t gy,
	output logic             out_vld,
	output ridb_pkg::side_t  out_side,
	output ridb_pkg::wide_t  out_num
);
	import ridb_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	diff_t ex_s1, ey_s1, vrx_s1, vry_s1, vgx_s1, vgy_s1;
	diff_t wrx_s1, wry_s1, wgx_s1, wgy_s1, hx_s1, hy_s1;

	prod_t exx_s2, eyy_s2, vrxx_s2, vryy_s2, vgxx_s2, vgyy_s2;
	prod_t wrxx_s2, wryy_s2, wgxx_s2, wgyy_s2, hxx_s2, hyy_s2;
	prod_t cr1_s2, cr0_s2, cg1_s2, cg0_s2, dr1_s2, dr0_s2, dg1_s2, dg0_s2;

	side_t  side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	side_t  side_s9, side_s10, side_s11, side_s12;
	cross_t cr_s3, cg_s3, dr_s3, dg_s3;
	cross_t cr_s4, cg_s4, ct_s4, dr_s4, dg_s4;
	sden_t  den_s4;

	logic   refl_c;
	cross_t ct_c;
	sden_t  den_c;
	logic   neg_den;
	side_t  side_c4;
	side_t  side_c12;

	mag_t  opa_s5 [4];
	mag_t  opb_s5 [4];
	logic  sg1_s5, sg2_s5, gate_s5;
	part_t pp_s6 [4][4];
	logic  sg1_s6, sg2_s6, gate_s6;
	wide_t p_s7 [4];
	logic  sg1_s7, sg2_s7, gate_s7;
	cmp_t  nu_s8, du_s8;
	wide_t num_s8, num_s9, num_s10, num_s11, num_s12;
	logic  gate_s8, gate_s9, gate_s10, gate_s11;
	cmp_t  a_s9, b_s9, du_s9;
	cmp_t  a1_s10, a2_s10, b1_s10, b2_s10, du_s10;
	cmp_t  am_s11, bm_s11, du_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (ce) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_comb begin
		refl_c  = (cr_s3 > 0 && cg_s3 > 0) || (cr_s3 < 0 && cg_s3 < 0);
		ct_c    = refl_c ? -cg_s3 : cg_s3;
		den_c   = sden_t'(cr_s3) - sden_t'(ct_c);
		neg_den = den_s4[MW-1];

		side_c4           = side_s3;
		side_c4.len_small = side_s3.len2 < sq_t'(LEN_TOL);
		side_c4.refl      = refl_c;

		side_c12        = side_s11;
		side_c12.direct = gate_s11 && (am_s11 <= du_s11) && (bm_s11 <= du_s11);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ex_s1  <= diff_t'(bx) - diff_t'(ax);
			ey_s1  <= diff_t'(by) - diff_t'(ay);
			vrx_s1 <= diff_t'(rx) - diff_t'(ax);
			vry_s1 <= diff_t'(ry) - diff_t'(ay);
			vgx_s1 <= diff_t'(gx) - diff_t'(ax);
			vgy_s1 <= diff_t'(gy) - diff_t'(ay);
			wrx_s1 <= diff_t'(rx) - diff_t'(bx);
			wry_s1 <= diff_t'(ry) - diff_t'(by);
			wgx_s1 <= diff_t'(gx) - diff_t'(bx);
			wgy_s1 <= diff_t'(gy) - diff_t'(by);
			hx_s1  <= diff_t'(rx) - diff_t'(gx);
			hy_s1  <= diff_t'(ry) - diff_t'(gy);

			exx_s2  <= ex_s1 * ex_s1;
			eyy_s2  <= ey_s1 * ey_s1;
			vrxx_s2 <= vrx_s1 * vrx_s1;
			vryy_s2 <= vry_s1 * vry_s1;
			vgxx_s2 <= vgx_s1 * vgx_s1;
			vgyy_s2 <= vgy_s1 * vgy_s1;
			wrxx_s2 <= wrx_s1 * wrx_s1;
			wryy_s2 <= wry_s1 * wry_s1;
			wgxx_s2 <= wgx_s1 * wgx_s1;
			wgyy_s2 <= wgy_s1 * wgy_s1;
			hxx_s2  <= hx_s1 * hx_s1;
			hyy_s2  <= hy_s1 * hy_s1;
			cr1_s2  <= ex_s1 * vry_s1;
			cr0_s2  <= ey_s1 * vrx_s1;
			cg1_s2  <= ex_s1 * vgy_s1;
			cg0_s2  <= ey_s1 * vgx_s1;
			dr1_s2  <= ex_s1 * vrx_s1;
			dr0_s2  <= ey_s1 * vry_s1;
			dg1_s2  <= ex_s1 * vgx_s1;
			dg0_s2  <= ey_s1 * vgy_s1;

			side_s3.len2      <= sq_t'(exx_s2 + eyy_s2);
			side_s3.sq_rg     <= sq_t'(hxx_s2 + hyy_s2);
			side_s3.sqa_r     <= sq_t'(vrxx_s2 + vryy_s2);
			side_s3.sqa_g     <= sq_t'(vgxx_s2 + vgyy_s2);
			side_s3.sqb_r     <= sq_t'(wrxx_s2 + wryy_s2);
			side_s3.sqb_g     <= sq_t'(wgxx_s2 + wgyy_s2);
			side_s3.len_small <= 1'b0;
			side_s3.refl      <= 1'b0;
			side_s3.direct    <= 1'b0;
			cr_s3 <= cross_t'(cr1_s2) - cross_t'(cr0_s2);
			cg_s3 <= cross_t'(cg1_s2) - cross_t'(cg0_s2);
			dr_s3 <= cross_t'(dr1_s2) + cross_t'(dr0_s2);
			dg_s3 <= cross_t'(dg1_s2) + cross_t'(dg0_s2);

			side_s4 <= side_c4;
			cr_s4  <= cr_s3;
			cg_s4  <= cg_s3;
			ct_s4  <= ct_c;
			dr_s4  <= dr_s3;
			dg_s4  <= dg_s3;
			den_s4 <= den_c;

			opa_s5[0] <= mag_of(sden_t'(cr_s4));
			opb_s5[0] <= mag_of(sden_t'(dg_s4));
			opa_s5[1] <= mag_of(sden_t'(ct_s4));
			opb_s5[1] <= mag_of(sden_t'(dr_s4));
			opa_s5[2] <= mag_of(den_s4);
			opb_s5[2] <= mag_t'(side_s4.len2);
			opa_s5[3] <= mag_of(sden_t'(cr_s4));
			opb_s5[3] <= mag_of(sden_t'(cg_s4));
			sg1_s5  <= cr_s4[XW-1] ^ dg_s4[XW-1] ^ neg_den;
			sg2_s5  <= ct_s4[XW-1] ^ dr_s4[XW-1] ^ neg_den;
			gate_s5 <= (mag_of(den_s4) > mag_t'(DEN_TOL)) &&
				(cr_s4 == 0 || ((cr_s4 > 0) == (den_s4 > 0)));
			side_s5 <= side_s4;

			for (int j = 0; j < 4; j++) begin
				pp_s6[j][0] <= opa_s5[j][HW-1:0] * opb_s5[j][HW-1:0];
				pp_s6[j][1] <= opa_s5[j][HW-1:0] * opb_s5[j][MW-1:HW];
				pp_s6[j][2] <= opa_s5[j][MW-1:HW] * opb_s5[j][HW-1:0];
				pp_s6[j][3] <= opa_s5[j][MW-1:HW] * opb_s5[j][MW-1:HW];
			end
			sg1_s6  <= sg1_s5;
			sg2_s6  <= sg2_s5;
			gate_s6 <= gate_s5;
			side_s6 <= side_s5;

			for (int j = 0; j < 4; j++) begin
				p_s7[j] <= (wide_t'(pp_s6[j][3]) << (2 * HW)) +
					((wide_t'(pp_s6[j][1]) + wide_t'(pp_s6[j][2])) << HW) +
					wide_t'(pp_s6[j][0]);
			end
			sg1_s7  <= sg1_s6;
			sg2_s7  <= sg2_s6;
			gate_s7 <= gate_s6;
			side_s7 <= side_s6;

			nu_s8   <= (sg1_s7 ? -cmp_t'(p_s7[0]) : cmp_t'(p_s7[0])) -
				(sg2_s7 ? -cmp_t'(p_s7[1]) : cmp_t'(p_s7[1]));
			du_s8   <= cmp_t'(p_s7[2]);
			num_s8  <= p_s7[3] << 2;
			gate_s8 <= gate_s7;
			side_s8 <= side_s7;

			a_s9    <= -nu_s8;
			b_s9    <= nu_s8 - du_s8;
			du_s9   <= du_s8;
			num_s9  <= num_s8;
			gate_s9 <= gate_s8;
			side_s9 <= side_s8;

			// scale by 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
			a1_s10   <= (a_s9 <<< 13) + (a_s9 <<< 10) + (a_s9 <<< 9);
			a2_s10   <= (a_s9 <<< 8) + (a_s9 <<< 4);
			b1_s10   <= (b_s9 <<< 13) + (b_s9 <<< 10) + (b_s9 <<< 9);
			b2_s10   <= (b_s9 <<< 8) + (b_s9 <<< 4);
			du_s10   <= du_s9;
			num_s10  <= num_s9;
			gate_s10 <= gate_s9;
			side_s10 <= side_s9;

			am_s11   <= a1_s10 + a2_s10;
			bm_s11   <= b1_s10 + b2_s10;
			du_s11   <= du_s10;
			num_s11  <= num_s10;
			gate_s11 <= gate_s10;
			side_s11 <= side_s10;

			side_s12 <= side_c12;
			num_s12  <= num_s11;
		end
	end

	assign out_vld  = vld_s12;
	assign out_side = side_s12;
	assign out_num  = num_s12;

endmodule

// ----- hdl/reflected_interval_distance_bound_unit.sv -----
// Lower bound on the root-to-goal path length through an interval, one
// transaction per cycle unless stalled. Coordinates are signed with 8
// fraction bits; the result is unsigned with the same scaling. The stages
// are the geometry and wide products, the bit-per-stage quotient of the
// mirrored-goal term, the radicand registers, the bit-pair-per-stage square
// roots and the final choice register. When out_stall holds a result, the
// whole pipeline freezes and in_stall rises; no transaction is dropped.
module reflected_interval_distance_bound_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] root_x,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] root_y,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] end_a_x,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] end_a_y,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] end_b_x,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] end_b_y,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] goal_x,
	input  logic signed [ridb_pkg::COORD_BITS-1:0] goal_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic        [ridb_pkg::OUT_BITS-1:0]   lower_bound
);
	import ridb_pkg::*;

	localparam int NRAD = 5;

	logic  ce;
	logic  f_vld;
	side_t f_side;
	wide_t f_num;
	quo_t  quo;

	side_t          dv_side_q [QW];
	logic  [QW-1:0] dv_vld_q;

	rad_t  rad_q [NRAD];
	flg_t  rflg_q;
	logic  rvld_q;

	root_t           root [NRAD];
	flg_t            sq_flg_q [RTW];
	logic  [RTW-1:0] sq_vld_q;

	res_t via_a, via_b, res;

	assign ce       = ~(out_valid & out_stall);
	assign in_stall = ~ce;

	ridb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_vld   (in_valid),
		.rx       (root_x[CW-1:0]),
		.ry       (root_y[CW-1:0]),
		.ax       (end_a_x[CW-1:0]),
		.ay       (end_a_y[CW-1:0]),
		.bx       (end_b_x[CW-1:0]),
		.by       (end_b_y[CW-1:0]),
		.gx       (goal_x[CW-1:0]),
		.gy       (goal_y[CW-1:0]),
		.out_vld  (f_vld),
		.out_side (f_side),
		.out_num  (f_num)
	);

	ridb_div u_div (
		.clk (clk),
		.ce  (ce),
		.num (f_num),
		.den (f_side.len2),
		.quo (quo)
	);

	genvar k;
	for (k = 0; k < NRAD; k++) begin : g_sqrt
		ridb_isqrt u_isqrt (
			.clk  (clk),
			.ce   (ce),
			.rad  (rad_q[k]),
			.root (root[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_q  <= '0;
			rvld_q    <= 1'b0;
			sq_vld_q  <= '0;
			out_valid <= 1'b0;
		end else if (ce) begin
			dv_vld_q  <= {dv_vld_q[QW-2:0], f_vld};
			rvld_q    <= dv_vld_q[QW-1];
			sq_vld_q  <= {sq_vld_q[RTW-2:0], rvld_q};
			out_valid <= sq_vld_q[RTW-1];
		end
	end

	always_comb begin
		via_a = res_t'(root[1]) + res_t'(root[2]);
		via_b = res_t'(root[3]) + res_t'(root[4]);
		if (sq_flg_q[RTW-1].len_small) begin
			res = via_a;
		end else if (sq_flg_q[RTW-1].direct) begin
			res = res_t'(root[0]);
		end else begin
			res = (via_a < via_b) ? via_a : via_b;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dv_side_q[0] <= f_side;
			for (int i = 1; i < QW; i++) begin
				dv_side_q[i] <= dv_side_q[i-1];
			end

			rad_q[0] <= rad_t'(dv_side_q[QW-1].sq_rg) +
				((dv_side_q[QW-1].refl && dv_side_q[QW-1].direct) ? rad_t'(quo) : '0);
			rad_q[1] <= rad_t'(dv_side_q[QW-1].sqa_r);
			rad_q[2] <= rad_t'(dv_side_q[QW-1].sqa_g);
			rad_q[3] <= rad_t'(dv_side_q[QW-1].sqb_r);
			rad_q[4] <= rad_t'(dv_side_q[QW-1].sqb_g);
			rflg_q.len_small <= dv_side_q[QW-1].len_small;
			rflg_q.direct    <= dv_side_q[QW-1].direct;

			sq_flg_q[0] <= rflg_q;
			for (int i = 1; i < RTW; i++) begin
				sq_flg_q[i] <= sq_flg_q[i-1];
			end

			lower_bound <= OUT_BITS'(res);
		end
	end

endmodule
